// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL of the SD card host, included by sdsh_seq.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define SDSH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SDSH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/sdsh_pkg.sv -----
`timescale 1ns / 1ps
package sdsh_pkg;

  localparam int BLOCK_BYTES_DEF = 512;

  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_XCHG = 2'd2;

  localparam logic [1:0] CFG_ACMD41_LIMIT = 2'd0;
  localparam logic [1:0] CFG_OCR_POLL     = 2'd1;
  localparam logic [1:0] CFG_WAKEUP       = 2'd2;
  localparam logic [1:0] CFG_V1_ROUNDS    = 2'd3;

  localparam logic [5:0] ACMD41_LIMIT_RST = 6'd50;
  localparam logic [3:0] OCR_POLL_RST     = 4'd5;
  localparam logic [4:0] WAKEUP_RST       = 5'd20;
  localparam logic [2:0] V1_ROUNDS_RST    = 3'd5;

  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_IF   = 6'd8;
  localparam logic [5:0] CMD_READ_BLK  = 6'd17;
  localparam logic [5:0] CMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;

  localparam logic [7:0]  CRC_CMD0    = 8'h95;
  localparam logic [7:0]  CRC_CMD8    = 8'h87;
  localparam logic [7:0]  CRC_DUMMY   = 8'h01;
  localparam logic [31:0] ARG_CMD8    = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  localparam logic [15:0] R7_ECHO     = 16'h01AA;
  localparam logic [7:0]  R1_IDLE     = 8'h01;
  localparam logic [7:0]  R1_READY    = 8'h00;
  localparam logic [7:0]  R1_ILLEGAL  = 8'h05;
  localparam logic [7:0]  BUS_IDLE    = 8'hFF;
  localparam logic [7:0]  DATA_TOKEN  = 8'hFE;
  localparam logic [7:0]  CMD_START   = 8'h40;
  localparam int          CCS_BIT     = 6;

  localparam int CMD_BYTES   = 6;
  localparam int R7_BYTES    = 4;
  localparam int GAP_BYTES   = 2;
  localparam int OCR_BYTES   = 4;
  localparam int TAIL_BYTES  = 10;
  localparam int PAD_BYTES   = 10;
  localparam int TRAIL_BYTES = 3;

  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_V1      = 2'd1;
  localparam logic [1:0] KIND_V2_SC   = 2'd2;
  localparam logic [1:0] KIND_V2_HC   = 2'd3;

  typedef struct packed {
    logic [5:0] acmd41_retry_limit;
    logic [3:0] ocr_poll_limit;
    logic [4:0] wakeup_bytes;
    logic [2:0] v1_init_rounds;
  } cfg_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       chip_select_low;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       data_last;
    logic       done_res;
    logic       failed;
    logic [1:0] card_kind;
  } res_t;

  function automatic logic [7:0] frame_byte(input logic [5:0] cmd, input logic [31:0] arg,
                                            input logic [7:0] crc, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CMD_START | {2'b00, cmd};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/sdsh_if.sv -----
`timescale 1ns / 1ps
interface sdsh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] sector;
  logic [7:0]  rx_byte;
  modport source(output valid, req_type, sector, rx_byte, input ready);
  modport sink(input valid, req_type, sector, rx_byte, output ready);
endinterface

interface sdsh_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       chip_select_low;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       data_last;
  logic       done_res;
  logic       failed;
  logic [1:0] card_kind;
  modport source(output valid, tx_byte, tx_valid, chip_select_low, data_byte, data_valid,
                 data_last, done_res, failed, card_kind, input ready);
  modport sink(input valid, tx_byte, tx_valid, chip_select_low, data_byte, data_valid,
               data_last, done_res, failed, card_kind, output ready);
endinterface

interface sdsh_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/sdsh_cfg.sv -----
`timescale 1ns / 1ps
module sdsh_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  sdsh_cfg_if.sink         cfg_i,
  output sdsh_pkg::cfg_t   cfg_o
);

  sdsh_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.acmd41_retry_limit <= sdsh_pkg::ACMD41_LIMIT_RST;
      cfg_q.ocr_poll_limit     <= sdsh_pkg::OCR_POLL_RST;
      cfg_q.wakeup_bytes       <= sdsh_pkg::WAKEUP_RST;
      cfg_q.v1_init_rounds     <= sdsh_pkg::V1_ROUNDS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sdsh_pkg::CFG_ACMD41_LIMIT: cfg_q.acmd41_retry_limit <= cfg_i.data[5:0];
        sdsh_pkg::CFG_OCR_POLL:     cfg_q.ocr_poll_limit     <= cfg_i.data[3:0];
        sdsh_pkg::CFG_WAKEUP:       cfg_q.wakeup_bytes       <= cfg_i.data[4:0];
        sdsh_pkg::CFG_V1_ROUNDS:    cfg_q.v1_init_rounds     <= cfg_i.data[2:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/sdsh_seq.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sdsh_seq #(
  parameter int BLOCK_BYTES = sdsh_pkg::BLOCK_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [1:0]       req_type_i,
  input  logic [31:0]      sector_i,
  input  logic [7:0]       rx_byte_i,
  input  sdsh_pkg::cfg_t   cfg_i,
  output sdsh_pkg::res_t   res_o
);

  localparam int IdxW = ($clog2(BLOCK_BYTES) > 5) ? $clog2(BLOCK_BYTES) : 5;

  localparam logic [IdxW:0]   CmdLen   = (IdxW + 1)'(sdsh_pkg::CMD_BYTES);
  localparam logic [IdxW:0]   R7Len    = (IdxW + 1)'(sdsh_pkg::R7_BYTES);
  localparam logic [IdxW:0]   GapLen   = (IdxW + 1)'(sdsh_pkg::GAP_BYTES);
  localparam logic [IdxW:0]   OcrLen   = (IdxW + 1)'(sdsh_pkg::OCR_BYTES);
  localparam logic [IdxW:0]   TailLen  = (IdxW + 1)'(sdsh_pkg::TAIL_BYTES);
  localparam logic [IdxW:0]   PadLen   = (IdxW + 1)'(sdsh_pkg::PAD_BYTES);
  localparam logic [IdxW:0]   TrailLen = (IdxW + 1)'(sdsh_pkg::TRAIL_BYTES);
  localparam logic [IdxW:0]   BlockLen = (IdxW + 1)'(BLOCK_BYTES);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(BLOCK_BYTES - 1);

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAKE, PH_CMD0, PH_CMD0_R, PH_CMD8, PH_CMD8_R, PH_R7,
    PH_CMD55, PH_CMD55_R, PH_GAP, PH_ACMD41, PH_ACMD41_R, PH_CMD58,
    PH_CMD58_R, PH_OCR, PH_TAIL, PH_V1_CMD55, PH_V1_PAD55, PH_V1_CMD41,
    PH_V1_PAD41, PH_CMD17, PH_CMD17_R, PH_TOKEN, PH_DATA, PH_TRAIL
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [5:0]      retry_q, retry_d;
  logic [2:0]      round_q, round_d;
  logic [15:0]     echo_q, echo_d;
  logic [7:0]      ocr_q, ocr_d;
  logic [1:0]      kind_q, kind_d;
  logic [31:0]     sector_q, sector_d;

  logic [IdxW:0]   idx_inc;
  logic [5:0]      retry_inc;
  logic [2:0]      round_inc;
  logic [15:0]     echo_nxt;
  logic [1:0]      tail_kind;
  logic [2:0]      frame_idx;
  logic            done, fail, dv, dlast;
  logic [7:0]      dbyte;

  assign idx_inc   = {1'b0, idx_q} + (IdxW + 1)'(1);
  assign retry_inc = retry_q + 6'd1;
  assign round_inc = round_q + 3'd1;
  assign echo_nxt  = {echo_q[7:0], rx_byte_i};
  assign tail_kind = ocr_q[sdsh_pkg::CCS_BIT] ? sdsh_pkg::KIND_V2_HC : sdsh_pkg::KIND_V2_SC;

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    retry_d  = retry_q;
    round_d  = round_q;
    echo_d   = echo_q;
    ocr_d    = ocr_q;
    kind_d   = kind_q;
    sector_d = sector_q;
    done     = 1'b0;
    fail     = 1'b0;
    dv       = 1'b0;
    dlast    = 1'b0;
    dbyte    = 8'h00;
    if (step_i) begin
      case (req_type_i)
        sdsh_pkg::REQ_INIT: begin
          kind_d  = sdsh_pkg::KIND_UNKNOWN;
          retry_d = '0;
          round_d = '0;
          echo_d  = '0;
          ocr_d   = '0;
          idx_d   = '0;
          phase_d = (cfg_i.wakeup_bytes == 5'd0) ? PH_CMD0 : PH_WAKE;
        end
        sdsh_pkg::REQ_READ: begin
          sector_d = sector_i;
          idx_d    = '0;
          phase_d  = PH_CMD17;
        end
        sdsh_pkg::REQ_XCHG: begin
          unique case (phase_q) inside
            PH_IDLE: ;
            PH_WAKE: begin
              idx_d = idx_inc[IdxW-1:0];
              if (idx_inc >= (IdxW + 1)'(cfg_i.wakeup_bytes)) begin
                idx_d   = '0;
                phase_d = PH_CMD0;
              end
            end
            PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41, PH_CMD58, PH_V1_CMD55,
            PH_V1_CMD41, PH_CMD17: begin
              idx_d = idx_inc[IdxW-1:0];
              if (idx_inc >= CmdLen) begin
                idx_d = '0;
                unique case (phase_q)
                  PH_CMD0:     phase_d = PH_CMD0_R;
                  PH_CMD8:     phase_d = PH_CMD8_R;
                  PH_CMD55:    phase_d = PH_CMD55_R;
                  PH_ACMD41:   phase_d = PH_ACMD41_R;
                  PH_V1_CMD55: phase_d = PH_V1_PAD55;
                  PH_V1_CMD41: phase_d = PH_V1_PAD41;
                  PH_CMD58: begin
                    if (cfg_i.ocr_poll_limit == 4'd0) begin
                      kind_d  = tail_kind;
                      phase_d = PH_TAIL;
                    end else begin
                      phase_d = PH_CMD58_R;
                    end
                  end
                  default:     phase_d = PH_CMD17_R;
                endcase
              end
            end
            PH_CMD0_R: begin
              if (rx_byte_i == sdsh_pkg::R1_IDLE) begin
                phase_d = PH_CMD8;
              end else if (rx_byte_i != sdsh_pkg::BUS_IDLE) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
                fail    = 1'b1;
              end
            end
            PH_CMD8_R: begin
              if (rx_byte_i == sdsh_pkg::R1_ILLEGAL) begin
                kind_d  = sdsh_pkg::KIND_V1;
                round_d = '0;
                if (cfg_i.v1_init_rounds == 3'd0) begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  phase_d = PH_V1_CMD55;
                end
              end else if (rx_byte_i == sdsh_pkg::R1_IDLE) begin
                kind_d  = sdsh_pkg::KIND_V2_SC;
                echo_d  = '0;
                phase_d = PH_R7;
              end
            end
            PH_R7: begin
              echo_d = echo_nxt;
              idx_d  = idx_inc[IdxW-1:0];
              if (idx_inc >= R7Len) begin
                idx_d = '0;
                if (echo_nxt == sdsh_pkg::R7_ECHO) begin
                  retry_d = '0;
                  phase_d = PH_CMD55;
                end else begin
                  phase_d = PH_CMD0;
                end
              end
            end
            PH_CMD55_R: begin
              if (rx_byte_i != sdsh_pkg::BUS_IDLE) begin
                phase_d = PH_GAP;
              end
            end
            PH_GAP: begin
              idx_d = idx_inc[IdxW-1:0];
              if (idx_inc >= GapLen) begin
                idx_d   = '0;
                phase_d = PH_ACMD41;
              end
            end
            PH_ACMD41_R: begin
              if (rx_byte_i == sdsh_pkg::R1_READY) begin
                ocr_d   = '0;
                phase_d = PH_CMD58;
              end else if (rx_byte_i != sdsh_pkg::BUS_IDLE) begin
                if (retry_inc >= cfg_i.acmd41_retry_limit) begin
                  retry_d = '0;
                  phase_d = PH_CMD0;
                end else begin
                  retry_d = retry_inc;
                  phase_d = PH_CMD55;
                end
              end
            end
            PH_CMD58_R: begin
              idx_d = idx_inc[IdxW-1:0];
              if (rx_byte_i == sdsh_pkg::R1_READY) begin
                idx_d   = '0;
                phase_d = PH_OCR;
              end else if (idx_inc >= (IdxW + 1)'(cfg_i.ocr_poll_limit)) begin
                idx_d   = '0;
                kind_d  = tail_kind;
                phase_d = PH_TAIL;
              end
            end
            PH_OCR: begin
              if (idx_q == '0) begin
                ocr_d = rx_byte_i;
              end
              idx_d = idx_inc[IdxW-1:0];
              if (idx_inc >= OcrLen) begin
                idx_d   = '0;
                kind_d  = tail_kind;
                phase_d = PH_TAIL;
              end
            end
            PH_TAIL: begin
              idx_d = idx_inc[IdxW-1:0];
              if (idx_inc >= TailLen) begin
                idx_d   = '0;
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
            PH_V1_PAD55: begin
              idx_d = idx_inc[IdxW-1:0];
              if (idx_inc >= PadLen) begin
                idx_d   = '0;
                phase_d = PH_V1_CMD41;
              end
            end
            PH_V1_PAD41: begin
              idx_d = idx_inc[IdxW-1:0];
              if (idx_inc >= PadLen) begin
                idx_d   = '0;
                round_d = round_inc;
                if (round_inc >= cfg_i.v1_init_rounds) begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  phase_d = PH_V1_CMD55;
                end
              end
            end
            PH_CMD17_R: begin
              if (rx_byte_i == sdsh_pkg::R1_READY) begin
                phase_d = PH_TOKEN;
              end
            end
            PH_TOKEN: begin
              if (rx_byte_i == sdsh_pkg::DATA_TOKEN) begin
                phase_d = PH_DATA;
              end
            end
            PH_DATA: begin
              dv    = 1'b1;
              dbyte = rx_byte_i;
              dlast = (idx_q == LastIdx);
              idx_d = idx_inc[IdxW-1:0];
              if (idx_inc >= BlockLen) begin
                idx_d   = '0;
                phase_d = PH_TRAIL;
              end
            end
            PH_TRAIL: begin
              idx_d = idx_inc[IdxW-1:0];
              if (idx_inc >= TrailLen) begin
                idx_d   = '0;
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
            default: begin
              idx_d   = '0;
              phase_d = PH_IDLE;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // The byte to send next follows from the updated phase and position.
  always_comb begin
    frame_idx = (idx_d > IdxW'(5)) ? 3'd5 : idx_d[2:0];
    res_o.tx_byte = sdsh_pkg::BUS_IDLE;
    unique case (phase_d) inside
      PH_CMD0: res_o.tx_byte = sdsh_pkg::frame_byte(sdsh_pkg::CMD_GO_IDLE, 32'd0,
                                                   sdsh_pkg::CRC_CMD0, frame_idx);
      PH_CMD8: res_o.tx_byte = sdsh_pkg::frame_byte(sdsh_pkg::CMD_SEND_IF, sdsh_pkg::ARG_CMD8,
                                                   sdsh_pkg::CRC_CMD8, frame_idx);
      PH_CMD55, PH_V1_CMD55:
        res_o.tx_byte = sdsh_pkg::frame_byte(sdsh_pkg::CMD_APP, 32'd0,
                                             sdsh_pkg::CRC_DUMMY, frame_idx);
      PH_ACMD41: res_o.tx_byte = sdsh_pkg::frame_byte(sdsh_pkg::CMD_OP_COND, sdsh_pkg::ARG_HCS,
                                                     sdsh_pkg::CRC_DUMMY, frame_idx);
      PH_V1_CMD41: res_o.tx_byte = sdsh_pkg::frame_byte(sdsh_pkg::CMD_OP_COND, 32'd0,
                                                       sdsh_pkg::CRC_DUMMY, frame_idx);
      PH_CMD58: res_o.tx_byte = sdsh_pkg::frame_byte(sdsh_pkg::CMD_READ_OCR, 32'd0,
                                                    sdsh_pkg::CRC_DUMMY, frame_idx);
      PH_CMD17: res_o.tx_byte = sdsh_pkg::frame_byte(sdsh_pkg::CMD_READ_BLK, sector_d,
                                                    sdsh_pkg::CRC_DUMMY, frame_idx);
      default: res_o.tx_byte = sdsh_pkg::BUS_IDLE;
    endcase
    res_o.tx_valid        = (phase_d != PH_IDLE);
    res_o.chip_select_low = (phase_d != PH_IDLE) && (phase_d != PH_WAKE);
    res_o.data_byte       = dbyte;
    res_o.data_valid      = dv;
    res_o.data_last       = dlast;
    res_o.done_res        = done;
    res_o.failed          = fail;
    res_o.card_kind       = kind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      idx_q    <= '0;
      retry_q  <= '0;
      round_q  <= '0;
      echo_q   <= '0;
      ocr_q    <= '0;
      kind_q   <= sdsh_pkg::KIND_UNKNOWN;
      sector_q <= '0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      retry_q  <= retry_d;
      round_q  <= round_d;
      echo_q   <= echo_d;
      ocr_q    <= ocr_d;
      kind_q   <= kind_d;
      sector_q <= sector_d;
    end
  end

  `SDSH_ASSERT(a_data_only_in_block, res_o.data_valid |-> step_i && phase_q == PH_DATA, "payload byte outside the data phase")
  `SDSH_ASSERT(a_block_end_to_trail, step_i && req_type_i == sdsh_pkg::REQ_XCHG && phase_q == PH_DATA && idx_q == LastIdx |=> phase_q == PH_TRAIL && idx_q == '0, "last payload byte did not enter the trailer")
  `SDSH_ASSERT_ALWAYS(a_fail_ends_sequence, res_o.failed |-> res_o.done_res && !res_o.tx_valid, "failure without ending the sequence")

endmodule

// ----- hdl/sd_card_spi_mode_host.sv -----
`timescale 1ns / 1ps
// SD card host sequencer for SPI mode, one transfer per SPI byte.
// The req_i channel carries requests: start init, start block read with a
// sector argument, or a completed byte exchange with the byte received.
// Every request produces exactly one transfer on res_o: the next byte to
// shift out with its chip select, an optional payload byte with a last flag,
// a done pulse with a failure flag, and the detected card kind.
// The cfg_i channel writes the retry, poll, wake-up and v1 round limits; it is
// always ready and should only be written while the block is idle.
// A request is captured in an input register, and its result is computed
// from it into the result register when that register is free or being
// drained; the result stays valid on res_o until it is taken.
// Throughput is one request per cycle as long as res_o is drained.
// When res_o stalls, the result register holds and the input register takes
// a request only while empty; once full, req_i.ready stays low until res_o moves.
// Reset clears the valid flags of both registers, returns the sequencer to
// idle with card kind unknown, and restores the default limits.
module sd_card_spi_mode_host #(
  parameter int BLOCK_BYTES = sdsh_pkg::BLOCK_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sdsh_req_if.sink   req_i,
  sdsh_res_if.source res_o,
  sdsh_cfg_if.sink   cfg_i
);

  sdsh_pkg::cfg_t cfg;
  sdsh_pkg::res_t res, res_q;

  logic        in_valid_q;
  logic [1:0]  req_type_q;
  logic [31:0] sector_q;
  logic [7:0]  rx_byte_q;
  logic        res_valid_q;
  logic        advance;

  assign advance     = in_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  sdsh_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  sdsh_seq #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .req_type_i (req_type_q),
    .sector_i   (sector_q),
    .rx_byte_i  (rx_byte_q),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_type_q <= req_i.req_type;
      sector_q   <= req_i.sector;
      rx_byte_q  <= req_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.tx_byte         = res_q.tx_byte;
  assign res_o.tx_valid        = res_q.tx_valid;
  assign res_o.chip_select_low = res_q.chip_select_low;
  assign res_o.data_byte       = res_q.data_byte;
  assign res_o.data_valid      = res_q.data_valid;
  assign res_o.data_last       = res_q.data_last;
  assign res_o.done_res        = res_q.done_res;
  assign res_o.failed          = res_q.failed;
  assign res_o.card_kind       = res_q.card_kind;

endmodule
